>>> hw/rtl/radix_digit_string_emitter_top_defines.svh
// Assertion macros for the radix digit string emitter checker.
// Included by rdse_checker.sv; expects clk and rst_n in scope.
`ifndef RADIX_DIGIT_STRING_EMITTER_TOP_DEFINES_SVH
`define RADIX_DIGIT_STRING_EMITTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RDSE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RDSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rdse_pkg.sv
// Shared types, constants and helpers of the radix digit string emitter.
// No dependencies; imported by every module of the block.
package rdse_pkg;

    localparam int VALUE_WIDTH    = 64;
    localparam int MAX_RADIX      = 16;
    localparam int RADIX_W        = 5;
    localparam int DIGIT_W        = 4;
    localparam int MAX_DIGITS     = 64;
    localparam int DCNT_W         = 7;
    localparam int DIDX_W         = 6;
    localparam int BITS_PER_CYCLE = 8;
    localparam int STEP_W         = 3;
    localparam int COUNT_IN_W     = 16;
    localparam int COUNT_W        = 17;
    localparam int SYM_W          = 8;
    localparam int PADDR_W        = 5;
    localparam int PDATA_W        = 64;

    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

    localparam logic FUNC_SIGNED = 1'b0;

    localparam logic [RADIX_W-1:0] BASE_LENGTH_RST = 5'd10;
    localparam logic [63:0] DIGITS_LOW_RST  = 64'h3736_3534_3332_3130;
    localparam logic [63:0] DIGITS_HIGH_RST = 64'h0000_0000_0000_3938;

    typedef enum logic [1:0] {
        REG_BASE_LENGTH = 2'd0,
        REG_DIGITS_LOW  = 2'd1,
        REG_DIGITS_HIGH = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic                   func;
        logic [VALUE_WIDTH-1:0] value;
        logic [COUNT_IN_W-1:0]  count_in;
    } num_t;

    typedef struct packed {
        logic [SYM_W-1:0]   char_out;
        logic               sign_before;
        logic               last;
        logic [COUNT_W-1:0] count_out;
    } sym_t;

    typedef struct packed {
        logic [RADIX_W-1:0] base_length;
        logic [63:0]        digits_low;
        logic [63:0]        digits_high;
    } cfg_t;

    // One classified number, queued between front and back.
    typedef struct packed {
        logic                   negative;
        logic [VALUE_WIDTH-1:0] mag;
        logic [RADIX_W-1:0]     radix;
        logic [COUNT_W-1:0]     count;
    } job_t;

    function automatic logic [SYM_W-1:0] sym_at(input logic [63:0] lo,
                                                 input logic [63:0] hi,
                                                 input logic [DIGIT_W-1:0] idx);
        logic [5:0] sh;
        sh = {idx[2:0], 3'b000};
        return idx[3] ? hi[sh +: SYM_W] : lo[sh +: SYM_W];
    endfunction

endpackage

>>> hw/rtl/rdse_front.sv
// Front end: accepts numbers, checks the digit table, forms the magnitude.
// Depends on rdse_pkg; feeds rdse_queue.
module rdse_front
    import rdse_pkg::*;
(
    input  logic num_valid,
    output logic num_stall,
    input  num_t num,
    input  cfg_t cfg,
    input  logic q_full,
    output logic q_push,
    output job_t q_data
);

    logic [RADIX_W-1:0]     len;
    logic                   negative;
    logic                   is_zero;
    logic                   base_ok;
    logic [SYM_W-1:0]       s;
    logic [VALUE_WIDTH-1:0] neg_v;

    always_comb
    begin
        len = (cfg.base_length > RADIX_W'(MAX_RADIX)) ? RADIX_W'(MAX_RADIX) : cfg.base_length;
        base_ok = (len >= RADIX_W'(2));
        for (int i = 0; i < MAX_RADIX; i++)
        begin
            s = sym_at(cfg.digits_low, cfg.digits_high, DIGIT_W'(i));
            if ((RADIX_W'(i) < len) && ((s == SYM_PLUS) || (s == SYM_MINUS)))
                base_ok = 1'b0;
        end
    end

    assign negative = (num.func == FUNC_SIGNED) && num.value[VALUE_WIDTH-1];
    assign is_zero  = (num.value == '0);
    assign neg_v    = '0 - num.value;

    // A bad table prints symbol 0: fold it into the zero-magnitude case.
    always_comb
    begin
        q_data.negative = base_ok && negative;
        q_data.mag      = !base_ok ? '0 : (negative ? neg_v : num.value);
        q_data.radix    = len;
        q_data.count    = {1'b0, num.count_in} + COUNT_W'(is_zero || negative);
    end

    assign num_stall = q_full;
    assign q_push    = num_valid && !q_full;

endmodule

>>> hw/rtl/rdse_queue.sv
// Two-entry job queue between the front end and the digit engine.
// Depends on rdse_pkg.
module rdse_queue
    import rdse_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t wdata,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t rdata
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

endmodule

>>> hw/rtl/rdse_back.sv
// Digit engine: divides by the radix 8 quotient bits per cycle, buffers
// digits, then plays them out most significant first. Depends on rdse_pkg.
module rdse_back
    import rdse_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic q_empty,
    input  job_t q_data,
    output logic q_pop,
    output logic sym_valid,
    input  logic sym_stall,
    output sym_t sym
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_READ = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [DCNT_W-1:0]      nd_reg, nd_next;
    logic [RADIX_W-1:0]     radix_reg, radix_next;
    logic                   neg_reg, neg_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [DIDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                   first_reg, first_next;
    sym_t                   out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    logic [DIGIT_W-1:0]     dig_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0]     rdata_reg;
    logic                   dig_we;
    logic [DIDX_W-1:0]      dig_waddr;
    logic [DIGIT_W-1:0]     dig_wdata;

    logic [BITS_PER_CYCLE-1:0] qbits;
    logic [DIGIT_W-1:0]        rem_step;
    logic [VALUE_WIDTH-1:0]    quo_step;
    logic                      out_free;

    // Restoring division of 8 bits against a radix of at most 16.
    always_comb
    begin
        logic [RADIX_W-1:0] r;
        logic [RADIX_W-1:0] t;
        r = {1'b0, rem_reg};
        for (int i = 0; i < BITS_PER_CYCLE; i++)
        begin
            t = {r[DIGIT_W-1:0], quo_reg[VALUE_WIDTH-1-i]};
            if (t >= radix_reg)
            begin
                qbits[BITS_PER_CYCLE-1-i] = 1'b1;
                r = t - radix_reg;
            end
            else
            begin
                qbits[BITS_PER_CYCLE-1-i] = 1'b0;
                r = t;
            end
        end
        rem_step = r[DIGIT_W-1:0];
        quo_step = {quo_reg[VALUE_WIDTH-BITS_PER_CYCLE-1:0], qbits};
    end

    assign out_free = !out_valid_reg || !sym_stall;

    always_comb
    begin
        state_next     = state_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        nd_next        = nd_reg;
        radix_next     = radix_reg;
        neg_next       = neg_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        first_next     = first_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && sym_stall;
        q_pop          = 1'b0;
        dig_we         = 1'b0;
        dig_waddr      = nd_reg[DIDX_W-1:0];
        dig_wdata      = rem_step;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    quo_next   = q_data.mag;
                    rem_next   = '0;
                    step_next  = '0;
                    nd_next    = '0;
                    radix_next = q_data.radix;
                    neg_next   = q_data.negative;
                    count_next = q_data.count;
                    first_next = 1'b1;
                    if (q_data.mag == '0)
                    begin
                        // Zero prints symbol 0 and adds no digits to the count.
                        dig_we      = 1'b1;
                        dig_waddr   = '0;
                        dig_wdata   = '0;
                        rd_idx_next = '0;
                        state_next  = ST_READ;
                    end
                    else
                        state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                quo_next  = quo_step;
                rem_next  = rem_step;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(VALUE_WIDTH / BITS_PER_CYCLE - 1))
                begin
                    dig_we   = 1'b1;
                    nd_next  = nd_reg + DCNT_W'(1);
                    rem_next = '0;
                    if (quo_step == '0)
                    begin
                        rd_idx_next = nd_reg[DIDX_W-1:0];
                        count_next  = count_reg + COUNT_W'(nd_next);
                        state_next  = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.char_out   = sym_at(cfg.digits_low, cfg.digits_high, rdata_reg);
                    out_next.sign_before = first_reg && neg_reg;
                    out_next.last       = (rd_idx_reg == '0);
                    out_next.count_out  = (rd_idx_reg == '0) ? count_reg : '0;
                    first_next          = 1'b0;
                    if (rd_idx_reg == '0)
                        state_next = ST_IDLE;
                    else
                    begin
                        rd_idx_next = rd_idx_reg - DIDX_W'(1);
                        state_next  = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        nd_reg     <= nd_next;
        radix_reg  <= radix_next;
        neg_reg    <= neg_next;
        count_reg  <= count_next;
        rd_idx_reg <= rd_idx_next;
        first_reg  <= first_next;
        out_reg    <= out_next;
    end

    // Digit buffer: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (dig_we)
            dig_mem[dig_waddr] <= dig_wdata;
        rdata_reg <= dig_mem[rd_idx_reg];
    end

    assign sym_valid = out_valid_reg;
    assign sym       = out_reg;

endmodule

>>> hw/rtl/radix_digit_string_emitter_top.sv
// Top level of the radix digit string emitter: register file and wiring.
// Depends on rdse_pkg, rdse_front, rdse_queue and rdse_back.
//
//   port group   dir   payload   transfer when
//   num          in    num_t     num_valid && !num_stall
//   sym          out   sym_t     sym_valid && !sym_stall
//   apb          in    64 bit    psel && penable && pwrite (pready tied high)
//
// The divider retires 8 quotient bits a cycle, one pass over the 64-bit quotient per digit;
// the digits are then played out, each through a buffer read and an output load, and the
// output load waits while the output is stalled. Zero and a bad table skip the divider.
// Up to two numbers wait in the queue while the engine works.
// Reset is asynchronous; it restores the registers and empties queue and output.
module radix_digit_string_emitter_top
    import rdse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               num_valid,
    output logic               num_stall,
    input  num_t               num,
    output logic               sym_valid,
    input  logic               sym_stall,
    output sym_t               sym,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t     cfg_reg;
    reg_idx_t reg_sel;
    logic     wr_en;
    logic     q_push, q_full, q_pop, q_empty;
    job_t     q_wdata, q_rdata;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:3]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_length <= BASE_LENGTH_RST;
            cfg_reg.digits_low  <= DIGITS_LOW_RST;
            cfg_reg.digits_high <= DIGITS_HIGH_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_BASE_LENGTH: cfg_reg.base_length <= pwdata[RADIX_W-1:0];
                REG_DIGITS_LOW:  cfg_reg.digits_low  <= pwdata;
                REG_DIGITS_HIGH: cfg_reg.digits_high <= pwdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_BASE_LENGTH: prdata = {{(PDATA_W-RADIX_W){1'b0}}, cfg_reg.base_length};
            REG_DIGITS_LOW:  prdata = cfg_reg.digits_low;
            REG_DIGITS_HIGH: prdata = cfg_reg.digits_high;
            default:         prdata = '0;
        endcase
    end

    rdse_front u_front (
        .num_valid (num_valid),
        .num_stall (num_stall),
        .num       (num),
        .cfg       (cfg_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    rdse_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    rdse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .sym_valid (sym_valid),
        .sym_stall (sym_stall),
        .sym       (sym)
    );

endmodule

>>> hw/rtl/rdse_checker.sv
// Port-level checks of the radix digit string emitter, bound to the top.
// Depends on rdse_pkg and radix_digit_string_emitter_top_defines.svh.
`include "radix_digit_string_emitter_top_defines.svh"

module rdse_checker
    import rdse_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic sym_valid,
    input logic sym_stall,
    input sym_t sym,
    input logic pready
);

    `RDSE_ASSERT_NEXT(a_sym_hold, sym_valid && sym_stall, sym_valid && $stable(sym), "stalled result changed")
    `RDSE_ASSERT_NOW(a_count_only_last, sym_valid && !sym.last, sym.count_out == '0, "count on non-final digit")
    `RDSE_ASSERT_NEXT(a_sign_first_only, sym_valid && !sym_stall && !sym.last, !sym_valid || !sym.sign_before, "minus flag after first digit")
    `RDSE_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready dropped")

endmodule

bind radix_digit_string_emitter_top rdse_checker u_rdse_checker (.*);

>>> bench/tb_radix_digit_string_emitter_top.sv
// Self-checking bench for radix_digit_string_emitter_top: random and directed numbers
// against a digit-string predictor, APB digit-table setup. Depends on rdse_pkg and RTL.
module tb_radix_digit_string_emitter_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rdse_pkg::*;

    localparam logic FUNC_UNSIGNED = 1'b1;
    localparam int   STALL_LIMIT   = 20000;
    localparam int   TAIL_CYCLES   = 700;
    localparam logic [63:0] HEX_LOW  = 64'h3736_3534_3332_3130;
    localparam logic [63:0] HEX_HIGH = 64'h6665_6463_6261_3938;

    class digit_scoreboard;
        logic [RADIX_W-1:0] base_length;
        logic [63:0]        digits_low;
        logic [63:0]        digits_high;
        sym_t               pending[$];
        int errors, numbers, symbols, negatives, bad_tables, longest, writes;

        function new();
            base_length = BASE_LENGTH_RST;
            digits_low  = DIGITS_LOW_RST;
            digits_high = DIGITS_HIGH_RST;
        endfunction

        function void set_reg(reg_idx_t idx, logic [63:0] d);
            writes++;
            case (idx)
                REG_BASE_LENGTH: base_length = d[RADIX_W-1:0];
                REG_DIGITS_LOW:  digits_low  = d;
                REG_DIGITS_HIGH: digits_high = d;
                default: ;
            endcase
        endfunction

        function logic [SYM_W-1:0] table_symbol(int idx);
            if (idx < 8)
                return digits_low[8*idx +: 8];
            return digits_high[8*(idx-8) +: 8];
        endfunction

        // Expand one accepted number into the symbols it must produce.
        function void note_number(num_t n);
            logic [63:0]        v;
            logic [63:0]        mag;
            logic [63:0]        radix;
            logic [COUNT_W-1:0] count;
            logic [3:0]         digs [64];
            bit                 neg;
            bit                 ok;
            int                 nd;
            sym_t               s;
            v     = n.value;
            neg   = (n.func == FUNC_SIGNED) && v[63];
            count = {1'b0, n.count_in};
            radix = (base_length > MAX_RADIX) ? 64'(MAX_RADIX) : 64'(base_length);
            numbers++;
            if (neg)
                negatives++;
            if (v == 0 || neg)
                count++;
            ok = (radix >= 2);
            for (int i = 0; i < radix; i++)
                if (table_symbol(i) == SYM_PLUS || table_symbol(i) == SYM_MINUS)
                    ok = 0;
            if (!ok)
            begin
                bad_tables++;
                s.char_out    = table_symbol(0);
                s.sign_before = 1'b0;
                s.last        = 1'b1;
                s.count_out   = count;
                pending.push_back(s);
                return;
            end
            mag = neg ? -v : v;
            nd  = 0;
            if (mag == 0)
            begin
                digs[0] = 4'd0;
                nd = 1;
            end
            else
            begin
                while (mag != 0)
                begin
                    digs[nd] = 4'(mag % radix);
                    mag = mag / radix;
                    nd++;
                    count++;
                end
            end
            if (nd > longest)
                longest = nd;
            for (int k = 0; k < nd; k++)
            begin
                s.char_out    = table_symbol(digs[nd-1-k]);
                s.sign_before = (k == 0) && neg;
                s.last        = (k == nd - 1);
                s.count_out   = (k == nd - 1) ? count : '0;
                pending.push_back(s);
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_symbol(sym_t got);
            sym_t want;
            symbols++;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected symbol %h", got));
                return;
            end
            want = pending.pop_front();
            if (got.char_out !== want.char_out)
                report($sformatf("char_out %h, want %h", got.char_out, want.char_out));
            if (got.sign_before !== want.sign_before)
                report($sformatf("sign_before %b, want %b", got.sign_before,
                                 want.sign_before));
            if (got.last !== want.last)
                report($sformatf("last %b, want %b", got.last, want.last));
            if (got.count_out !== want.count_out)
                report($sformatf("count_out %0d, want %0d", got.count_out, want.count_out));
        endtask

        task close_out();
            if (pending.size() != 0)
                report($sformatf("%0d symbols never arrived", pending.size()));
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               num_valid = 1'b0;
    logic               num_stall;
    num_t               num = '0;
    logic               sym_valid;
    logic               sym_stall = 1'b0;
    sym_t               sym;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    digit_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int idle_cycles = 0;

    radix_digit_string_emitter_top dut (
        .clk(clk), .rst_n(rst_n),
        .num_valid(num_valid), .num_stall(num_stall), .num(num),
        .sym_valid(sym_valid), .sym_stall(sym_stall), .sym(sym),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        sym_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (num_valid && !num_stall)
                sb.note_number(num);
            if (sym_valid && !sym_stall)
                sb.check_symbol(sym);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (num_valid && !num_stall) || (sym_valid && !sym_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(reg_idx_t idx, logic [63:0] d);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(8 * idx);
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, d);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold valid across back-to-back transfers; drop it only for an idle gap.
    task automatic put_number(num_t n);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            num_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        num_valid <= 1'b1;
        num       <= n;
        do @(posedge clk); while (num_stall);
    endtask

    task automatic put(logic f, logic [63:0] v, logic [15:0] c);
        num_t n;
        n.func     = f;
        n.value    = v;
        n.count_in = c;
        put_number(n);
    endtask

    task automatic settle();
        num_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic num_t random_number();
        num_t n;
        n.func     = 1'($urandom_range(0, 1));
        n.count_in = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 9))
            0: n.value = '0;
            1: n.value = 64'($urandom_range(1, 300));
            2: n.value = -64'($urandom_range(1, 300));
            3: n.value = $urandom_range(0, 1) ? 64'h8000_0000_0000_0000 : '1;
            4, 5: n.value = {$urandom, $urandom} >> $urandom_range(0, 63);
            default: n.value = {$urandom, $urandom};
        endcase
        return n;
    endfunction

    // Mostly legal radices; some too short, some saturating, some tables with a sign.
    task automatic shuffle_config();
        logic [63:0]      len_word;
        logic [63:0]      lo;
        logic [63:0]      hi;
        logic [SYM_W-1:0] sign;
        int               pos;
        len_word = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: len_word[4:0] = 5'($urandom_range(0, 1));
            1: len_word[4:0] = 5'($urandom_range(17, 31));
            default: len_word[4:0] = 5'($urandom_range(2, 16));
        endcase
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        if ($urandom_range(0, 5) == 0)
        begin
            pos  = $urandom_range(0, 15);
            sign = $urandom_range(0, 1) ? SYM_PLUS : SYM_MINUS;
            if (pos < 8)
                lo[8*pos +: 8] = sign;
            else
                hi[8*(pos-8) +: 8] = sign;
        end
        write_reg(REG_BASE_LENGTH, len_word);
        write_reg(REG_DIGITS_LOW, lo);
        write_reg(REG_DIGITS_HIGH, hi);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 19;
        recv_idle_pct = 63;

        // Decimal table out of reset.
        put(FUNC_SIGNED, 64'd0, 16'd0);
        put(FUNC_SIGNED, '1, 16'hFFFF);
        put(FUNC_SIGNED, 64'h8000_0000_0000_0000, 16'hFFFF);
        put(FUNC_UNSIGNED, '1, 16'd0);
        put(FUNC_UNSIGNED, 64'd0, 16'hFFFF);
        put(FUNC_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF, 16'd7);
        put(FUNC_UNSIGNED, 64'h8000_0000_0000_0000, 16'd1);
        put(FUNC_SIGNED, 64'd5, 16'd100);
        settle();

        // Binary: longest strings.
        write_reg(REG_BASE_LENGTH, 64'd2);
        put(FUNC_UNSIGNED, '1, 16'hFFFF);
        put(FUNC_SIGNED, 64'h8000_0000_0000_0000, 16'd0);
        put(FUNC_SIGNED, '1, 16'd3);
        settle();

        write_reg(REG_BASE_LENGTH, 64'd16);
        write_reg(REG_DIGITS_HIGH, HEX_HIGH);
        put(FUNC_UNSIGNED, '1, 16'd0);
        put(FUNC_SIGNED, -64'h123, 16'd9);
        settle();

        // Radix too short.
        write_reg(REG_BASE_LENGTH, 64'd1);
        put(FUNC_SIGNED, -64'd5, 16'd0);
        put(FUNC_UNSIGNED, 64'd42, 16'hFFFF);
        settle();
        write_reg(REG_BASE_LENGTH, 64'd0);
        put(FUNC_UNSIGNED, 64'd0, 16'd4);
        settle();

        // Length above range saturates to sixteen.
        write_reg(REG_BASE_LENGTH, '1);
        put(FUNC_UNSIGNED, 64'hDEAD_BEEF_0123_4567, 16'd2);
        put(FUNC_SIGNED, -64'd1000, 16'd0);
        settle();

        // Minus sign inside the used part of the table.
        write_reg(REG_BASE_LENGTH, 64'd10);
        write_reg(REG_DIGITS_HIGH, DIGITS_HIGH_RST);
        write_reg(REG_DIGITS_LOW, 64'h3736_3534_2D32_3130);
        put(FUNC_SIGNED, -64'd7, 16'd10);
        settle();

        // Plus sign past the used part: table still valid.
        write_reg(REG_DIGITS_LOW, HEX_LOW);
        write_reg(REG_DIGITS_HIGH, 64'h0000_002B_0000_3938);
        put(FUNC_SIGNED, -64'd7, 16'd10);
        settle();

        write_reg(REG_BASE_LENGTH, 64'd2);
        write_reg(REG_DIGITS_LOW, 64'h3736_3534_3332_312B);
        put(FUNC_SIGNED, 64'd6, 16'd0);
        settle();

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 19 : (mode == 1) ? 63 : 0;
            recv_idle_pct = (mode == 0) ? 63 : (mode == 1) ? 19 : 0;
            for (int seg = 0; seg < 4; seg++)
            begin
                shuffle_config();
                repeat (20) put_number(random_number());
                settle();
            end
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        sb.close_out();
        $display("run covered %0d numbers (%0d negative, %0d on a bad digit table)",
                 sb.numbers, sb.negatives, sb.bad_tables);
        $display("%0d symbols checked, longest string %0d digits, %0d register writes",
                 sb.symbols, sb.longest, sb.writes);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
